// ===== rtl/tcde_pkg.sv =====
`timescale 1ns / 1ps

package tcde_pkg;

  // counter and channel sizing
  localparam int unsigned CntW   = 8;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned CodeW  = 3;

  // debounce count after reset
  localparam logic [CntW-1:0] DebounceCountRst = 8'd5;

  // channel indexes, also the upper bits of an event code
  localparam logic [1:0] ChLeft   = 2'd0;
  localparam logic [1:0] ChMiddle = 2'd1;
  localparam logic [1:0] ChRight  = 2'd2;

  // input item
  typedef struct packed {
    logic mode;
    logic left_tape;
    logic middle_tape;
    logic right_tape;
  } tcde_in_t;

  // result item
  typedef struct packed {
    logic             event_valid;
    logic [CodeW-1:0] event_code;
    logic             event_level;
    logic [NumCh-1:0] raw_mask;
    logic [NumCh-1:0] stable_mask;
  } tcde_out_t;

  // per-channel update control
  typedef struct packed {
    logic upd;
    logic init;
  } tcde_chan_ctrl_t;

  // event code: channel times two, plus one for an off transition
  function automatic logic [CodeW-1:0] ev_code(logic [1:0] ch, logic level);
    return {ch, ~level};
  endfunction

endpackage

// ===== rtl/tcde_chan.sv =====
`timescale 1ns / 1ps

module tcde_chan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcde_pkg::tcde_chan_ctrl_t    ctrl_i,
  input  logic                         sample_i,
  input  logic                         stable_i,
  input  logic [tcde_pkg::CntW-1:0]    thresh_i,
  output logic                         flip_o
);
  import tcde_pkg::*;

  logic            last_q, last_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // run counter: saturate on repeat, restart at one on change
  always_comb begin
    last_d = last_q;
    cnt_d  = cnt_q;
    if (ctrl_i.init) begin
      last_d = sample_i;
      cnt_d  = '0;
    end else if (sample_i == last_q) begin
      if (cnt_q < thresh_i) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else begin
      last_d = sample_i;
      cnt_d  = CntW'(1);
    end
  end

  // change request once the run is long enough
  assign flip_o = !ctrl_i.init && (cnt_d >= thresh_i) && (sample_i != stable_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.upd) begin
      last_q <= last_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/three_channel_debounce_event.sv =====
`timescale 1ns / 1ps

// Three-channel debouncer for left, middle and right sensor lines. Each input
// item is one sample of all three lines (or an initialize request); each item
// gives exactly one result item with the raw and debounced masks and at most
// one level-change event, left taking priority over middle over right. The
// block takes one item per clock while in_stall_o is low: the item is captured
// in an input register, and the per-channel run counters and the event select
// are updated as it moves on into the result register, which holds the result
// while the output side stalls.
// The debounce count register may be rewritten only while no item is in flight.
module three_channel_debounce_event (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcde_pkg::CntW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tcde_pkg::tcde_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tcde_pkg::tcde_out_t                out_data_o
);
  import tcde_pkg::*;

  logic [CntW-1:0]  thresh_q;
  logic             in_vld_q;
  tcde_in_t         in_q;
  logic             out_vld_q;
  tcde_out_t        out_q, out_d;
  logic [NumCh-1:0] stable_q, stable_d;
  logic [NumCh-1:0] sample;
  logic [NumCh-1:0] flip;
  logic             advance;
  logic             in_take;
  tcde_chan_ctrl_t  chan_ctrl;

  // handshake
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= DebounceCountRst;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  assign sample         = {in_q.right_tape, in_q.middle_tape, in_q.left_tape};
  assign chan_ctrl.upd  = advance;
  assign chan_ctrl.init = in_q.mode;

  // per-channel run counters
  for (genvar ch = 0; ch < NumCh; ch++) begin : g_chan
    tcde_chan u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (chan_ctrl),
      .sample_i (sample[ch]),
      .stable_i (stable_q[ch]),
      .thresh_i (thresh_q),
      .flip_o   (flip[ch])
    );
  end

  // event select, left first
  always_comb begin
    stable_d          = stable_q;
    out_d             = '0;
    out_d.raw_mask    = sample;
    if (in_q.mode) begin
      stable_d = sample;
    end else begin
      priority if (flip[0]) begin
        stable_d[0]       = sample[0];
        out_d.event_valid = 1'b1;
        out_d.event_level = sample[0];
        out_d.event_code  = ev_code(ChLeft, sample[0]);
      end else if (flip[1]) begin
        stable_d[1]       = sample[1];
        out_d.event_valid = 1'b1;
        out_d.event_level = sample[1];
        out_d.event_code  = ev_code(ChMiddle, sample[1]);
      end else if (flip[2]) begin
        stable_d[2]       = sample[2];
        out_d.event_valid = 1'b1;
        out_d.event_level = sample[2];
        out_d.event_code  = ev_code(ChRight, sample[2]);
      end else begin
        out_d.event_valid = 1'b0;
      end
    end
    out_d.stable_mask = stable_d;
  end

  // debounced levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
    end else if (advance) begin
      stable_q <= stable_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // at most one debounced level changes per item
  a_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.mode |-> $countones(stable_d ^ stable_q) <= 1)
    else $error("more than one debounced level changed");

  // a reported event matches the stable mask of its channel
  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_valid |->
      (out_data_o.event_code[2:1] == ChLeft &&
       out_data_o.event_level == out_data_o.stable_mask[0]) ||
      (out_data_o.event_code[2:1] == ChMiddle &&
       out_data_o.event_level == out_data_o.stable_mask[1]) ||
      (out_data_o.event_code[2:1] == ChRight &&
       out_data_o.event_level == out_data_o.stable_mask[2]))
    else $error("event level disagrees with stable mask");

  // initialize items report no event and load the sample
  a_init_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.mode |=>
      !out_data_o.event_valid && out_data_o.stable_mask == out_data_o.raw_mask)
    else $error("initialize item result wrong");

  // a held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcde_pkg::*;

  // item modes
  localparam logic ModeSample = 1'b0;
  localparam logic ModeInit   = 1'b1;

  // sample masks, bit0 left, bit1 middle, bit2 right
  localparam logic [NumCh-1:0] MaskNone = 3'b000;
  localparam logic [NumCh-1:0] MaskAll  = 3'b111;

  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned SettleCycles = 4;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CntW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tcde_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tcde_out_t           out_data_o;

  // debouncer mirror: threshold, levels, last samples, run lengths
  logic [CntW-1:0]     count_limit = DebounceCountRst;
  logic [NumCh-1:0]    stable_lvl  = '0;
  logic [NumCh-1:0]    prev_sample = '0;
  logic [CntW-1:0]     run_len [NumCh] = '{default: '0};

  tcde_out_t           due_results [$];
  tcde_out_t           want_res;
  int unsigned         fail_count  = 0;

  // idling controls shared with the driver processes
  bit                  tx_quiet    = 1'b0;
  bit                  rx_quiet    = 1'b0;
  bit                  rx_hold_req = 1'b0;

  three_channel_debounce_event dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // next debounced result for one accepted item, advances the mirror state
  function automatic tcde_out_t predict_debounce(tcde_in_t item);
    tcde_out_t        res;
    logic [NumCh-1:0] smp;
    logic             found;
    smp   = {item.right_tape, item.middle_tape, item.left_tape};
    res   = '0;
    found = 1'b0;
    res.raw_mask = smp;
    if (item.mode == ModeInit) begin
      stable_lvl  = smp;
      prev_sample = smp;
      for (int ch = 0; ch < NumCh; ch++) run_len[ch] = '0;
    end else begin
      // run counters: saturate on repeat, restart on change
      for (int ch = 0; ch < NumCh; ch++) begin
        if (smp[ch] == prev_sample[ch]) begin
          if (run_len[ch] < count_limit) run_len[ch]++;
        end else begin
          prev_sample[ch] = smp[ch];
          run_len[ch]     = CntW'(1);
        end
      end
      // first settled channel that disagrees wins
      for (int ch = 0; ch < NumCh; ch++) begin
        if (!found && run_len[ch] >= count_limit && smp[ch] != stable_lvl[ch]) begin
          stable_lvl[ch]  = smp[ch];
          res.event_valid = 1'b1;
          res.event_level = smp[ch];
          res.event_code  = CodeW'(2 * ch + (smp[ch] ? 0 : 1));
          found           = 1'b1;
        end
      end
    end
    res.stable_mask = stable_lvl;
    return res;
  endfunction

  // input capture and result compare, both at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) due_results.push_back(predict_debounce(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing expected: %p", out_data_o);
          fail_count++;
        end else begin
          want_res = due_results.pop_front();
          if (out_data_o.event_valid !== want_res.event_valid) begin
            $error("event_valid: expected %0d, got %0d",
                   want_res.event_valid, out_data_o.event_valid);
            fail_count++;
          end
          if (out_data_o.event_code !== want_res.event_code) begin
            $error("event_code: expected %0d, got %0d",
                   want_res.event_code, out_data_o.event_code);
            fail_count++;
          end
          if (out_data_o.event_level !== want_res.event_level) begin
            $error("event_level: expected %0d, got %0d",
                   want_res.event_level, out_data_o.event_level);
            fail_count++;
          end
          if (out_data_o.raw_mask !== want_res.raw_mask) begin
            $error("raw_mask: expected %b, got %b",
                   want_res.raw_mask, out_data_o.raw_mask);
            fail_count++;
          end
          if (out_data_o.stable_mask !== want_res.stable_mask) begin
            $error("stable_mask: expected %b, got %b",
                   want_res.stable_mask, out_data_o.stable_mask);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random stall before each item, optional long hold-off
  initial begin
    int unsigned gap;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // offer one item after a random gap, return once taken
  task automatic send_item(input logic mode, input logic [NumCh-1:0] smp);
    int unsigned gap;
    tcde_in_t    item;
    item.mode        = mode;
    item.left_tape   = smp[0];
    item.middle_tape = smp[1];
    item.right_tape  = smp[2];
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [CntW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    count_limit = value;
  endtask

  // reset count: priority between channels, glitches, initialize items
  task automatic test_directed();
    send_item(ModeInit, MaskNone);
    repeat (7) send_item(ModeSample, MaskAll);
    send_item(ModeSample, 3'b010);
    repeat (7) send_item(ModeSample, MaskNone);
    send_item(ModeInit, 3'b101);
    repeat (2) send_item(ModeSample, 3'b101);
    send_item(ModeInit, 3'b010);
    repeat (5) send_item(ModeSample, MaskNone);
  endtask

  // count of one, zero, the maximum with saturation, and two
  task automatic test_count_extremes();
    write_count(8'd1);
    send_item(ModeInit, MaskNone);
    send_item(ModeSample, MaskAll);
    send_item(ModeSample, MaskAll);
    send_item(ModeSample, MaskAll);
    send_item(ModeSample, 3'b110);
    send_item(ModeSample, 3'b011);

    // zero count: any differing sample settles at once
    write_count(8'd0);
    repeat (3) send_item(ModeSample, MaskAll);
    repeat (3) send_item(ModeSample, MaskNone);
    send_item(ModeSample, 3'b101);
    send_item(ModeInit, 3'b010);
    send_item(ModeSample, 3'b101);

    // maximum count, run long enough to saturate
    write_count(8'd255);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_item(ModeInit, MaskNone);
    repeat (258) send_item(ModeSample, MaskAll);
    repeat (3) send_item(ModeSample, MaskNone);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    write_count(8'd2);
    repeat (4) send_item(ModeSample, 3'b100);
    repeat (4) send_item(ModeSample, 3'b011);
  endtask

  // runs of equal samples with random content, some glitches and inits
  task automatic test_random_runs();
    int unsigned      sent;
    int unsigned      pick;
    int unsigned      len;
    logic [NumCh-1:0] smp;
    for (int chunk = 0; chunk < 5; chunk++) begin
      write_count(chunk == 2 ? 8'd0 : CntW'($urandom_range(1, 6)));
      tx_quiet = (chunk == 3);
      rx_quiet = (chunk == 3);
      sent = 0;
      while (sent < 70) begin
        pick = $urandom_range(0, 19);
        smp  = NumCh'($urandom_range(0, 7));
        if (pick == 0) begin
          send_item(ModeInit, smp);
          sent++;
        end else if (pick < 3) begin
          send_item(ModeSample, smp);
          sent++;
        end else begin
          len = $urandom_range(1, count_limit + 3);
          repeat (len) send_item(ModeSample, smp);
          sent += len;
        end
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side holds off while samples keep coming
  task automatic test_backpressure();
    write_count(8'd3);
    rx_hold_req = 1'b1;
    tx_quiet    = 1'b1;
    for (int k = 0; k < 40; k++) send_item(ModeSample, NumCh'($urandom_range(0, 7)));
    tx_quiet    = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_count_extremes();
    test_random_runs();
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
